// ----- hw/rtl/u8dec_pkg.sv -----
// Shared constants, types and the per-byte decode function of the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CpWidth   = 31;
   localparam int unsigned RemWidth  = 3;

   // Byte class masks and the pattern each class must show under its mask
   localparam logic [ByteWidth-1:0] CONT_MASK  = 8'hc0;
   localparam logic [ByteWidth-1:0] CONT_CODE  = 8'h80;
   localparam logic [ByteWidth-1:0] ASCII_MASK = 8'h80;
   localparam logic [ByteWidth-1:0] ASCII_CODE = 8'h00;
   localparam logic [ByteWidth-1:0] LEAD2_MASK = 8'he0;
   localparam logic [ByteWidth-1:0] LEAD2_CODE = 8'hc0;
   localparam logic [ByteWidth-1:0] LEAD3_MASK = 8'hf0;
   localparam logic [ByteWidth-1:0] LEAD3_CODE = 8'he0;
   localparam logic [ByteWidth-1:0] LEAD4_MASK = 8'hf8;
   localparam logic [ByteWidth-1:0] LEAD4_CODE = 8'hf0;
   localparam logic [ByteWidth-1:0] LEAD5_MASK = 8'hfc;
   localparam logic [ByteWidth-1:0] LEAD5_CODE = 8'hf8;
   localparam logic [ByteWidth-1:0] LEAD6_MASK = 8'hfe;
   localparam logic [ByteWidth-1:0] LEAD6_CODE = 8'hfc;

   // Continuation bytes still expected after each lead byte
   localparam logic [RemWidth-1:0] REM_NONE  = 3'd0;
   localparam logic [RemWidth-1:0] REM_LEAD2 = 3'd1;
   localparam logic [RemWidth-1:0] REM_LEAD3 = 3'd2;
   localparam logic [RemWidth-1:0] REM_LEAD4 = 3'd3;
   localparam logic [RemWidth-1:0] REM_LEAD5 = 3'd4;
   localparam logic [RemWidth-1:0] REM_LEAD6 = 3'd5;
   localparam logic [RemWidth-1:0] REM_MAX   = REM_LEAD6;

   typedef struct packed {
      logic                emit;
      logic                error;
      logic [CpWidth-1:0]  code_point;
      logic [CpWidth-1:0]  partial;
      logic [RemWidth-1:0] remaining;
      logic                failed;
   } dec_result_type;

   // Decode one byte against the current sequence state
   function automatic dec_result_type decode_byte(
      input logic [ByteWidth-1:0] c,
      input logic [CpWidth-1:0]   pv,
      input logic [RemWidth-1:0]  rem,
      input logic                 failed
   );
      dec_result_type r;
      logic [CpWidth-1:0] shifted;
      r.emit       = 1'b0;
      r.error      = 1'b0;
      r.code_point = '0;
      r.partial    = pv;
      r.remaining  = rem;
      r.failed     = failed;
      shifted      = {pv[CpWidth-7:0], c[5:0]};
      if (!failed) begin
         priority if ((c & CONT_MASK) == CONT_CODE) begin
            if (rem == REM_NONE) begin
               // stray continuation: flag once, drop rest of string
               r.failed = 1'b1;
               r.emit   = 1'b1;
               r.error  = 1'b1;
            end else begin
               r.partial   = shifted;
               r.remaining = rem - 3'd1;
               if (rem == 3'd1) begin
                  r.emit       = 1'b1;
                  r.code_point = shifted;
               end
            end
         end else if ((c & ASCII_MASK) == ASCII_CODE) begin
            r.remaining  = REM_NONE;
            r.emit       = 1'b1;
            r.code_point = {{(CpWidth-ByteWidth){1'b0}}, c};
         end else if ((c & LEAD2_MASK) == LEAD2_CODE) begin
            r.remaining = REM_LEAD2;
            r.partial   = {{(CpWidth-5){1'b0}}, c[4:0]};
         end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
            r.remaining = REM_LEAD3;
            r.partial   = {{(CpWidth-4){1'b0}}, c[3:0]};
         end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
            r.remaining = REM_LEAD4;
            r.partial   = {{(CpWidth-3){1'b0}}, c[2:0]};
         end else if ((c & LEAD5_MASK) == LEAD5_CODE) begin
            r.remaining = REM_LEAD5;
            r.partial   = {{(CpWidth-2){1'b0}}, c[1:0]};
         end else if ((c & LEAD6_MASK) == LEAD6_CODE) begin
            r.remaining = REM_LEAD6;
            r.partial   = {{(CpWidth-1){1'b0}}, c[0]};
         end else begin
            // 0xFE / 0xFF
            r.failed = 1'b1;
            r.emit   = 1'b1;
            r.error  = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_to_code_point_decoder_unit.sv -----
// Top level of the UTF-8 to code point decoder: input register, decode, result register.
//
//   channel | direction | tdata                       | tuser        | tlast
//   req_    | in        | [7:0] byte_value            | -            | string_end
//   rsp_    | out       | [30:0] code_point, [31] pad | decode_error | -
//
// One byte per cycle unless the output stalls; each result is registered after decode.
// The sequence state (partial value, bytes remaining, failed flag) updates in the same
// cycle the byte leaves the input register, which sets the one-byte-per-cycle rate.
// Synchronous active-high reset clears valids and sequence state.
// A stalled result register holds the input register; the input register still
// accepts a new word whenever its current word moves on in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_code_point_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tlast,   // string_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [30:0] code_point, [31] zero
   output logic             rsp_tuser    // [0] decode_error
);
   import u8dec_pkg::*;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;

   // Sequence state
   logic [CpWidth-1:0]   partial_ff, partial_in;
   logic [RemWidth-1:0]  rem_ff, rem_in;
   logic                 failed_ff, failed_in;

   // Result register
   logic                 out_valid_ff, out_valid_in;
   logic [CpWidth-1:0]   out_cp_ff;
   logic                 out_err_ff;

   logic                 advance;
   logic                 req_fire;
   dec_result_type       dec;

   // Move the held word on when the result slot is free or being emptied
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      dec = decode_byte(in_byte_ff, partial_ff, rem_ff, failed_ff);
   end

   // Next values: clear state after the marked last byte
   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (in_valid_ff && !advance);
      out_valid_in = advance ? dec.emit : (out_valid_ff && !rsp_tready);
      partial_in   = partial_ff;
      rem_in       = rem_ff;
      failed_in    = failed_ff;
      if (advance) begin
         if (in_last_ff) begin
            partial_in = '0;
            rem_in     = REM_NONE;
            failed_in  = 1'b0;
         end else begin
            partial_in = dec.partial;
            rem_in     = dec.remaining;
            failed_in  = dec.failed;
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         partial_ff   <= '0;
         rem_ff       <= REM_NONE;
         failed_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         partial_ff   <= partial_in;
         rem_ff       <= rem_in;
         failed_ff    <= failed_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && dec.emit) begin
         out_cp_ff  <= dec.code_point;
         out_err_ff <= dec.error;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_cp_ff};
   assign rsp_tuser  = out_err_ff;

   // Checks
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 32'd0))
      else $error("error result carries a nonzero code point");

   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (rem_ff == REM_NONE && !failed_ff && partial_ff == '0))
      else $error("sequence state not cleared after string end");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && failed_ff) |-> !dec.emit)
      else $error("failed string produced a result");

   assert property (@(posedge clock) disable iff (reset)
      rem_ff <= REM_MAX)
      else $error("bytes remaining out of range");

   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stalled with empty input register");

endmodule

`default_nettype wire

// ----- sim/tb_utf8_to_code_point_decoder_unit.sv -----
// Self-checking testbench for the UTF-8 to code point decoder unit.
`timescale 1ns / 1ps

module tb_utf8_to_code_point_decoder_unit;
   import u8dec_pkg::*;

   typedef struct packed {
      logic [ByteWidth-1:0] value;
      logic                 last;
   } byte_word_type;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               decode_error;
   } point_word_type;

   localparam int RANDOM_BYTES = 750;
   localparam int IDLE_PCT     = 36;
   localparam int CALM_START   = 400;
   localparam int CALM_STOP    = 700;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ByteWidth-1:0] req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tuser;

   byte_word_type        pending_bytes[$];
   point_word_type       expected_points[$];
   logic [ByteWidth-1:0] string_bytes[$];

   // Decoder state mirrored for prediction
   logic [CpWidth-1:0]  seq_value  = '0;
   logic [RemWidth-1:0] seq_left   = '0;
   logic                str_failed = 1'b0;

   logic byte_taken = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   int   points_seen = 0;
   int   errors_seen = 0;
   int   bytes_taken = 0;
   int   strings_taken = 0;

   utf8_to_code_point_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] byte_value
      .req_tlast  (req_tlast),   // string_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [30:0] code_point, [31] zero
      .rsp_tuser  (rsp_tuser)    // [0] decode_error
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Number of leading one bits, which classifies a UTF-8 byte
   function automatic int lead_ones(input logic [ByteWidth-1:0] b);
      int n;
      n = 0;
      while (n < 8 && b[7-n]) n++;
      return n;
   endfunction

   // Advance the mirrored decoder by one byte and record any code point it yields
   task automatic decode_next_byte(input logic [ByteWidth-1:0] b, input logic last);
      int             ones;
      logic           emit;
      point_word_type res;
      ones = lead_ones(b);
      emit = 1'b0;
      res  = '0;
      if (!str_failed) begin
         case (ones)
            0: begin
               seq_left       = '0;
               res.code_point = CpWidth'(b);
               emit           = 1'b1;
            end
            1: begin
               if (seq_left == 0) begin
                  // continuation with nothing open: flag and abandon the string
                  str_failed       = 1'b1;
                  res.decode_error = 1'b1;
                  emit             = 1'b1;
               end else begin
                  seq_value = {seq_value[CpWidth-7:0], b[5:0]};
                  seq_left  = seq_left - 1'b1;
                  if (seq_left == 0) begin
                     res.code_point = seq_value;
                     emit           = 1'b1;
                  end
               end
            end
            2, 3, 4, 5, 6: begin
               // a new lead drops whatever was open
               seq_left  = RemWidth'(ones - 1);
               seq_value = CpWidth'(b & (8'hff >> (ones + 1)));
            end
            default: begin
               str_failed       = 1'b1;
               res.decode_error = 1'b1;
               emit             = 1'b1;
            end
         endcase
      end
      if (emit) expected_points.push_back(res);
      if (last) begin
         seq_value  = '0;
         seq_left   = '0;
         str_failed = 1'b0;
      end
   endtask

   task automatic queue_byte(input logic [ByteWidth-1:0] b, input logic last = 1'b0);
      byte_word_type w;
      w.value = b;
      w.last  = last;
      pending_bytes.push_back(w);
   endtask

   // Append one well-formed character of the given encoded length
   task automatic build_char(input int len);
      logic [ByteWidth-1:0] b;
      if (len == 1) begin
         string_bytes.push_back(8'($urandom_range(0, 127)));
      end else begin
         b = (8'hff << (8 - len)) | (8'($urandom) & (8'hff >> (len + 1)));
         string_bytes.push_back(b);
         repeat (len - 1) string_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
   endtask

   // Build one random string, mostly well formed, and queue it with its end mark
   task automatic queue_random_string(inout int count);
      int r;
      int len;
      string_bytes.delete();
      if ($urandom_range(0, 99) < 6) begin
         repeat ($urandom_range(1, 8)) string_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(0, 99);
            len = (r < 40) ? 1 : (r < 60) ? 2 : (r < 75) ? 3 : (r < 87) ? 4 : (r < 94) ? 5 : 6;
            build_char(len);
         end
         // corrupt a byte now and then
         if ($urandom_range(0, 99) < 12)
            string_bytes[$urandom_range(0, string_bytes.size() - 1)] = 8'($urandom);
         // cut the tail short now and then
         if ($urandom_range(0, 99) < 10 && string_bytes.size() > 1)
            void'(string_bytes.pop_back());
      end
      foreach (string_bytes[i]) queue_byte(string_bytes[i], i == string_bytes.size() - 1);
      count += string_bytes.size();
   endtask

   // Drive request words and the response ready at the falling edge
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_tready <= (cycle_count >= CALM_START && cycle_count < CALM_STOP) ||
                    ($urandom_range(0, 99) >= IDLE_PCT);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || byte_taken) begin
         if (pending_bytes.size() != 0 &&
             ((cycle_count >= CALM_START && cycle_count < CALM_STOP) ||
              $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes[0].value;
            req_tlast  <= pending_bytes[0].last;
            void'(pending_bytes.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Check result words, then predict from the byte taken on this edge
   always @(posedge clock) begin
      byte_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected result word: expected none, got tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               if (rsp_tdata !== {1'b0, expected_points[0].code_point} ||
                   rsp_tuser !== expected_points[0].decode_error) begin
                  $display("%0t: mismatch: expected tdata %h tuser %b, got tdata %h tuser %b",
                           $time, {1'b0, expected_points[0].code_point},
                           expected_points[0].decode_error, rsp_tdata, rsp_tuser);
                  mismatch_count++;
               end
               if (expected_points[0].decode_error) errors_seen++;
               else points_seen++;
               void'(expected_points.pop_front());
            end
         end
         if (req_tvalid && req_tready) begin
            byte_taken = 1'b1;
            bytes_taken++;
            if (req_tlast) strings_taken++;
            decode_next_byte(req_tdata, req_tlast);
         end
      end
   end

   // Hard stop if the run hangs
   initial begin
      #2_000_000;
      $display("utf8_to_code_point_decoder_unit test failed");
      $finish;
   end

   initial begin
      int random_count;
      random_count = 0;

      // ASCII extremes, a two-byte character, then the largest six-byte value
      queue_byte(8'h00);
      queue_byte(8'h7f);
      queue_byte(8'hc2);
      queue_byte(8'ha9);
      queue_byte(8'hfd);
      repeat (4) queue_byte(8'hbf);
      queue_byte(8'hbf, 1'b1);
      // lead byte while a sequence is open, then ASCII while one is open
      queue_byte(8'he2);
      queue_byte(8'hc3);
      queue_byte(8'ha9);
      queue_byte(8'he2);
      queue_byte(8'h41);
      // truncated tail at the string end
      queue_byte(8'hf8);
      queue_byte(8'h88);
      queue_byte(8'h80, 1'b1);
      // stray continuation; the rest of the string is dropped
      queue_byte(8'h80);
      queue_byte(8'hc2);
      queue_byte(8'h41, 1'b1);
      // 0xFE and 0xFF bytes
      queue_byte(8'hfe, 1'b1);
      queue_byte(8'hff);
      queue_byte(8'hf0, 1'b1);

      while (random_count < RANDOM_BYTES) queue_random_string(random_count);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain input, then results, then watch for stray words
      while (pending_bytes.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_points.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d bytes in %0d strings; checked %0d code points and %0d error words.",
               bytes_taken, strings_taken, points_seen, errors_seen);
      if (mismatch_count == 0) begin
         $display("utf8_to_code_point_decoder_unit test passed");
      end else begin
         $display("utf8_to_code_point_decoder_unit test failed");
      end
      $finish;
   end

endmodule
